/* hdl/great_circle_distance_defines.svh */
// assertion macros for the great circle distance block
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define GCD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define GCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/gcd_pkg.sv */
// shared types, constants and arithmetic helpers for the great circle distance block
package gcd_pkg;

	typedef logic signed [31:0] q30_t;
	typedef logic [31:0] angle_t;

	localparam angle_t PI_Q30 = 32'd3373259426;
	localparam angle_t HALF_PI_Q30 = 32'd1686629713;
	localparam q30_t ONE_Q30 = 32'sd1073741824;
	localparam logic signed [33:0] ONE_W = 34'sd1073741824;
	localparam int NUM_TERMS = 10;
	localparam int BISECT_STEPS = 34;
	localparam int SC_LAT = 33;
	localparam int DEG_DIV = 45;
	localparam logic [15:0] RADIUS_RESET = 16'd6371;
	localparam logic [25:0] DIST_MAX = 26'd52707000;

	// divisor of taylor term k
	function automatic int unsigned term_div(input bit sine, input int unsigned k);
		return sine ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
	endfunction

	// clamp a wide sum to [-1, 1] in q30
	function automatic q30_t clamp1(input logic signed [33:0] v);
		if (v > ONE_W) begin
			return ONE_Q30;
		end
		if (v < -ONE_W) begin
			return -ONE_Q30;
		end
		return q30_t'(v);
	endfunction

	// q30 product, truncated toward zero
	function automatic q30_t mulq(input q30_t a, input q30_t b);
		logic [31:0] ua;
		logic [31:0] ub;
		logic [63:0] p;
		q30_t m;
		ua = a[31] ? 32'(-a) : 32'(a);
		ub = b[31] ? 32'(-b) : 32'(b);
		p = 64'(ua) * 64'(ub);
		m = q30_t'(p[61:30]);
		return (a[31] ^ b[31]) ? -m : m;
	endfunction

endpackage

/* hdl/gcd_series.sv */
// pipelined taylor series for sine or cosine, three stages per term
module gcd_series #(
	parameter bit SINE = 1'b0
) (
	input  logic                clk,
	input  logic                en,
	input  logic [30:0]         t0,
	input  logic [31:0]         x2,
	output logic signed [33:0]  sum
);
	import gcd_pkg::*;

	logic [30:0]        t_l   [0:NUM_TERMS];
	logic [31:0]        x2_l  [0:NUM_TERMS];
	logic signed [33:0] sum_l [0:NUM_TERMS];

	assign t_l[0]   = t0;
	assign x2_l[0]  = x2;
	assign sum_l[0] = signed'({3'b000, t0});
	assign sum      = sum_l[NUM_TERMS];

	for (genvar k = 1; k <= NUM_TERMS; k++) begin : g_term
		localparam int unsigned D = term_div(SINE, k);
		localparam logic [32:0] M = 33'((64'd1 << 33) / 64'(D));

		logic [63:0]        ta_prod;
		logic [65:0]        qb_prod;
		logic [33:0]        rc;
		logic [30:0]        tc_next;
		logic [32:0]        p_s1;
		logic [31:0]        x2_s1;
		logic signed [33:0] sum_s1;
		logic [32:0]        qe_s2;
		logic [32:0]        p_s2;
		logic [31:0]        x2_s2;
		logic signed [33:0] sum_s2;
		logic [30:0]        t_s3;
		logic [31:0]        x2_s3;
		logic signed [33:0] sum_s3;

		// term product, then reciprocal estimate, then correction
		assign ta_prod = 64'(t_l[k-1]) * 64'(x2_l[k-1]);
		assign qb_prod = 66'(p_s1) * 66'(M);
		assign rc      = 34'(p_s2) - 34'(qe_s2) * 34'(D);
		assign tc_next = (rc >= 34'(D)) ? 31'(qe_s2 + 33'd1) : 31'(qe_s2);

		always_ff @(posedge clk) begin
			if (en) begin
				p_s1   <= ta_prod[62:30];
				x2_s1  <= x2_l[k-1];
				sum_s1 <= sum_l[k-1];
				qe_s2  <= qb_prod[65:33];
				p_s2   <= p_s1;
				x2_s2  <= x2_s1;
				sum_s2 <= sum_s1;
				t_s3   <= tc_next;
				x2_s3  <= x2_s2;
				if (k % 2 == 1) begin
					sum_s3 <= sum_s2 - signed'({3'b000, tc_next});
				end else begin
					sum_s3 <= sum_s2 + signed'({3'b000, tc_next});
				end
			end
		end

		assign t_l[k]   = t_s3;
		assign x2_l[k]  = x2_s3;
		assign sum_l[k] = sum_s3;
	end

endmodule

/* hdl/gcd_sincos.sv */
// pipelined sine and cosine of an angle in [0, pi], q30, with side band
module gcd_sincos #(
	parameter bit WANT_SIN = 1'b1,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                v_in,
	input  gcd_pkg::angle_t     x,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                v_out,
	output gcd_pkg::q30_t       s_out,
	output gcd_pkg::q30_t       c_out,
	output logic [SIDE_W-1:0]   side_out
);
	import gcd_pkg::*;

	angle_t             a_c;
	logic               flip_c;
	angle_t             ua_c;
	logic [30:0]        ua_s1;
	logic               flip_s1;
	logic [63:0]        sq;
	logic [30:0]        ua_s2;
	logic [31:0]        x2_s2;
	logic               flip_s2;
	logic [29:0]        flip_sr;
	logic signed [33:0] cos_sum;
	logic signed [33:0] cos_fix;
	logic [SC_LAT-1:0]  v_sr;
	logic [SIDE_W-1:0]  side_sr [0:SC_LAT-1];

	// reduce to [0, pi/2], remembering whether cosine flips sign
	assign a_c    = (x > PI_Q30) ? PI_Q30 : x;
	assign flip_c = a_c > HALF_PI_Q30;
	assign ua_c   = flip_c ? PI_Q30 - a_c : a_c;
	assign sq     = 64'(ua_s1) * 64'(ua_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1   <= ua_c[30:0];
			flip_s1 <= flip_c;
			ua_s2   <= ua_s1;
			x2_s2   <= sq[61:30];
			flip_s2 <= flip_s1;
			flip_sr <= {flip_sr[28:0], flip_s2};
		end
	end

	// cosine series
	gcd_series #(.SINE(1'b0)) u_cos (
		.clk (clk),
		.en  (en),
		.t0  (31'(ONE_Q30)),
		.x2  (x2_s2),
		.sum (cos_sum)
	);

	assign cos_fix = flip_sr[29] ? -cos_sum : cos_sum;

	always_ff @(posedge clk) begin
		if (en) begin
			c_out <= clamp1(cos_fix);
		end
	end

	// sine series where needed
	if (WANT_SIN) begin : g_sin
		logic signed [33:0] sin_sum;

		gcd_series #(.SINE(1'b1)) u_sin (
			.clk (clk),
			.en  (en),
			.t0  (ua_s2),
			.x2  (x2_s2),
			.sum (sin_sum)
		);

		always_ff @(posedge clk) begin
			if (en) begin
				s_out <= clamp1(sin_sum);
			end
		end
	end else begin : g_nosin
		assign s_out = '0;
	end

	// valid bits travel alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sr <= '0;
		end else if (en) begin
			v_sr <= {v_sr[SC_LAT-2:0], v_in};
		end
	end

	// side band travels alongside
	always_ff @(posedge clk) begin
		if (en) begin
			side_sr[0] <= side_in;
			for (int i = 1; i < SC_LAT; i++) begin
				side_sr[i] <= side_sr[i-1];
			end
		end
	end

	assign v_out    = v_sr[SC_LAT-1];
	assign side_out = side_sr[SC_LAT-1];

endmodule

/* hdl/great_circle_distance.sv */
// great circle distance by the spherical law of cosines, fully pipelined top level
//
// Input channel: in_valid/in_ready with the four coordinates in degrees,
// signed fixed point with ANGLE_FRAC_BITS fraction bits. Output channel:
// out_valid/out_ready with distance (km, 8 fraction bits) and valid_res.
// A request whose coordinates are out of range gives distance 0, valid_res 0.
// cfg_we/cfg_wdata write the sphere radius in km; write it only while idle.
// Throughput: one request per cycle while the output is not stalled. The
// pipeline has 1235 register stages:
// 7 input and conversion stages, 33 stages of sine/cosine, 3 combining
// stages, 34 bisection steps of 35 stages each (one cosine pipeline per
// step) and 2 scaling stages.
// Reset clears all valid bits and sets the radius to 6371 km.
// When out_valid is high and out_ready low the whole pipeline holds,
// in_ready drops, and nothing is lost or repeated.
module great_circle_distance #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] first_latitude,
	input  logic signed [23:0] second_latitude,
	input  logic signed [24:0] first_longitude,
	input  logic signed [24:0] second_longitude,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [25:0]        distance,
	output logic               valid_res,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata
);
	import gcd_pkg::*;

	localparam int M_W = ANGLE_FRAC_BITS + 8;
	localparam int PR_W = ANGLE_FRAC_BITS + 40;
	localparam longint DEG90 = longint'(90) <<< ANGLE_FRAC_BITS;
	localparam longint DEG180 = longint'(180) <<< ANGLE_FRAC_BITS;
	localparam longint DEG360 = longint'(360) <<< ANGLE_FRAC_BITS;
	localparam logic [32:0] M45 = 33'((64'd1 << 38) / 64'(DEG_DIV));

	logic en;
	logic [15:0] radius_q;

	logic               v_s1;
	logic signed [23:0] lat1_s1;
	logic signed [23:0] lat2_s1;
	logic signed [24:0] lon1_s1;
	logic signed [24:0] lon2_s1;
	logic               v_s2;
	logic               ok_s2;
	logic [M_W-1:0]     phi1_s2;
	logic [M_W-1:0]     phi2_s2;
	logic signed [25:0] dl_s2;
	logic [25:0]        dabs;
	logic               v_s3;
	logic               ok_s3;
	logic [M_W-1:0]     mag_s3 [0:2];
	logic               v_s4;
	logic               ok_s4;
	logic [PR_W-1:0]    pr_s4 [0:2];
	logic               v_s5;
	logic               ok_s5;
	logic [37:0]        n_s5 [0:2];
	logic [51:0]        pl_s5 [0:2];
	logic [51:0]        ph_s5 [0:2];
	logic               v_s6;
	logic               ok_s6;
	logic [37:0]        n_s6 [0:2];
	logic [32:0]        qe_s6 [0:2];
	logic               v_s7;
	logic               ok_s7;
	angle_t             rad_s7 [0:2];

	logic               v_sc [0:2];
	q30_t               s_sc [0:2];
	q30_t               c_sc [0:2];
	logic               ok_sc [0:2];

	logic               v_p1;
	logic               ok_p1;
	q30_t               m1_p1;
	q30_t               m2_p1;
	q30_t               cd_p1;
	logic               v_p2;
	logic               ok_p2;
	q30_t               m3_p2;
	q30_t               m2_p2;
	logic               v_p3;
	logic               ok_p3;
	q30_t               c_p3;

	angle_t             lo_b [0:BISECT_STEPS];
	angle_t             hi_b [0:BISECT_STEPS];
	q30_t               c_b  [0:BISECT_STEPS];
	logic               ok_b [0:BISECT_STEPS];
	logic               v_b  [0:BISECT_STEPS];

	logic               v_f1;
	logic               ok_f1;
	logic [47:0]        prod_f1;
	logic [47:0]        rsum;

	// one enable for the whole pipeline; output register is the last stage
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// front end valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// absolute longitude difference
	assign dabs = dl_s2[25] ? 26'(-dl_s2) : 26'(dl_s2);

	// range check, colatitudes, angle magnitudes and degree to radian conversion
	always_ff @(posedge clk) begin
		if (en) begin
			lat1_s1 <= first_latitude;
			lat2_s1 <= second_latitude;
			lon1_s1 <= first_longitude;
			lon2_s1 <= second_longitude;

			ok_s2 <= !(64'(lat1_s1) < -DEG90 || 64'(lat1_s1) > DEG90 ||
				64'(lat2_s1) < -DEG90 || 64'(lat2_s1) > DEG90 ||
				64'(lon1_s1) < -DEG180 || 64'(lon1_s1) > DEG180 ||
				64'(lon2_s1) < -DEG180 || 64'(lon2_s1) > DEG180);
			phi1_s2 <= M_W'(DEG90 - 64'(lat1_s1));
			phi2_s2 <= M_W'(DEG90 - 64'(lat2_s1));
			dl_s2   <= 26'(lon1_s1) - 26'(lon2_s1);

			ok_s3     <= ok_s2;
			mag_s3[0] <= ok_s2 ? phi1_s2 : '0;
			mag_s3[1] <= ok_s2 ? phi2_s2 : '0;
			if (!ok_s2) begin
				mag_s3[2] <= '0;
			end else if (64'(dabs) > DEG180) begin
				mag_s3[2] <= M_W'(DEG360 - 64'(dabs));
			end else begin
				mag_s3[2] <= M_W'(dabs);
			end

			ok_s4 <= ok_s3;
			ok_s5 <= ok_s4;
			ok_s6 <= ok_s5;
			ok_s7 <= ok_s6;
			for (int i = 0; i < 3; i++) begin
				pr_s4[i] <= PR_W'(mag_s3[i]) * PR_W'(PI_Q30);
				n_s5[i]  <= pr_s4[i][ANGLE_FRAC_BITS+39:ANGLE_FRAC_BITS+2];
				pl_s5[i] <= 52'(pr_s4[i][ANGLE_FRAC_BITS+20:ANGLE_FRAC_BITS+2]) * 52'(M45);
				ph_s5[i] <= 52'(pr_s4[i][ANGLE_FRAC_BITS+39:ANGLE_FRAC_BITS+21]) * 52'(M45);
				n_s6[i]  <= n_s5[i];
				qe_s6[i] <= 33'(((71'(ph_s5[i]) << 19) + 71'(pl_s5[i])) >> 38);
				if (38'(n_s6[i]) - 38'(qe_s6[i]) * 38'(DEG_DIV) >= 38'(DEG_DIV)) begin
					rad_s7[i] <= 32'(qe_s6[i] + 33'd1);
				end else begin
					rad_s7[i] <= 32'(qe_s6[i]);
				end
			end
		end
	end

	// sine and cosine of both colatitudes, cosine of the longitude difference
	for (genvar i = 0; i < 3; i++) begin : g_sc
		gcd_sincos #(.WANT_SIN(i < 2), .SIDE_W(1)) u_sc (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (v_s7),
			.x        (rad_s7[i]),
			.side_in  (ok_s7),
			.v_out    (v_sc[i]),
			.s_out    (s_sc[i]),
			.c_out    (c_sc[i]),
			.side_out (ok_sc[i])
		);
	end

	// combine into the cosine of the central angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
		end else if (en) begin
			v_p1 <= v_sc[0] && v_sc[1] && v_sc[2];
			v_p2 <= v_p1;
			v_p3 <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_p1 <= ok_sc[0] && ok_sc[1] && ok_sc[2];
			m1_p1 <= mulq(s_sc[0], s_sc[1]);
			m2_p1 <= mulq(c_sc[0], c_sc[1]);
			cd_p1 <= c_sc[2];
			ok_p2 <= ok_p1;
			m3_p2 <= mulq(m1_p1, cd_p1);
			m2_p2 <= m2_p1;
			ok_p3 <= ok_p2;
			c_p3  <= clamp1(34'(m3_p2) + 34'(m2_p2));
		end
	end

	assign lo_b[0] = '0;
	assign hi_b[0] = PI_Q30;
	assign c_b[0]  = c_p3;
	assign ok_b[0] = ok_p3;
	assign v_b[0]  = v_p3;

	// arc cosine by bisection, one cosine pipeline per step
	for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_step
		logic   v_m;
		angle_t lo_m;
		angle_t hi_m;
		angle_t mid_m;
		q30_t   c_m;
		logic   ok_m;
		logic   v_u;
		q30_t   cv_u;
		angle_t lo_u;
		angle_t hi_u;
		angle_t mid_u;
		q30_t   c_u;
		logic   ok_u;
		logic   v_x;
		angle_t lo_x;
		angle_t hi_x;
		q30_t   c_x;
		logic   ok_x;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_m <= 1'b0;
				v_x <= 1'b0;
			end else if (en) begin
				v_m <= v_b[k];
				v_x <= v_u;
			end
		end

		// midpoint of the bracket
		always_ff @(posedge clk) begin
			if (en) begin
				lo_m  <= lo_b[k];
				hi_m  <= hi_b[k];
				mid_m <= lo_b[k] + ((hi_b[k] - lo_b[k]) >> 1);
				c_m   <= c_b[k];
				ok_m  <= ok_b[k];
			end
		end

		gcd_sincos #(.WANT_SIN(1'b0), .SIDE_W(129)) u_cos (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (v_m),
			.x        (mid_m),
			.side_in  ({lo_m, hi_m, mid_m, c_m, ok_m}),
			.v_out    (v_u),
			.s_out    (),
			.c_out    (cv_u),
			.side_out ({lo_u, hi_u, mid_u, c_u, ok_u})
		);

		// raise the lower bound to the midpoint while the cosine is still above the target, else lower the upper bound
		always_ff @(posedge clk) begin
			if (en) begin
				c_x  <= c_u;
				ok_x <= ok_u;
				if (cv_u > c_u) begin
					lo_x <= mid_u;
					hi_x <= hi_u;
				end else begin
					lo_x <= lo_u;
					hi_x <= mid_u;
				end
			end
		end

		assign lo_b[k+1] = lo_x;
		assign hi_b[k+1] = hi_x;
		assign c_b[k+1]  = c_x;
		assign ok_b[k+1] = ok_x;
		assign v_b[k+1]  = v_x;
	end

	// scale by radius and round to 8 fraction bits
	assign rsum = prod_f1 + 48'(1 << 21);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_f1      <= v_b[BISECT_STEPS];
			out_valid <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_f1     <= ok_b[BISECT_STEPS];
			prod_f1   <= 48'(lo_b[BISECT_STEPS]) * 48'(radius_q);
			valid_res <= ok_f1;
			distance  <= ok_f1 ? rsum[47:22] : '0;
		end
	end

`include "great_circle_distance_defines.svh"

	`GCD_ASSERT_IMPL(a_zero_when_invalid, out_valid && !valid_res, distance == '0, "out of range request gave a nonzero distance")
	`GCD_ASSERT_IMPL(a_dist_bound, out_valid, distance <= DIST_MAX, "distance beyond half circumference")
	`GCD_ASSERT_IMPL(a_cos_clamped, v_b[0], (c_b[0] <= ONE_Q30) && (c_b[0] >= -ONE_Q30), "central angle cosine not clamped")
	`GCD_ASSERT_IMPL(a_bracket_order, v_b[BISECT_STEPS], lo_b[BISECT_STEPS] <= hi_b[BISECT_STEPS], "bisection bracket inverted")
	`GCD_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_s1, "accepted request did not enter the pipeline")

endmodule
